FILE: rtl/hrhp_pkg.sv
package hrhp_pkg;

   localparam int MAX_FIELD_LEN = 1024;
   localparam int FC_W          = $clog2(MAX_FIELD_LEN + 1);
   localparam int POS_W         = 10;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_G          = 8'h47;
   localparam logic [7:0] CH_P          = 8'h50;
   localparam logic [7:0] CH_SP         = 8'h20;
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CASE_OFFSET   = 8'h20;
   localparam logic [7:0] VERSION_RADIX = 8'd10;

   typedef enum logic [2:0] {
      KIND_URI    = 3'd0,
      KIND_KEY    = 3'd1,
      KIND_VALUE  = 3'd2,
      KIND_LINE   = 3'd3,
      KIND_HEADER = 3'd4,
      KIND_HEAD   = 3'd5,
      KIND_ERROR  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      METHOD_NONE = 2'd0,
      METHOD_GET  = 2'd1,
      METHOD_POST = 2'd2
   } method_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       byte_out;
      logic [POS_W-1:0] position;
      method_type       method;
      logic [7:0]       version;
      logic             last;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

   function automatic rsp_item_type field_item(input kind_type k, input logic [7:0] b,
                                               input logic [POS_W-1:0] p);
      rsp_item_type r;
      r          = '0;
      r.kind     = k;
      r.byte_out = b;
      r.position = p;
      r.method   = METHOD_NONE;
      return r;
   endfunction

   function automatic rsp_item_type ctrl_item(input kind_type k, input method_type m,
                                              input logic [7:0] v);
      rsp_item_type r;
      r         = '0;
      r.kind    = k;
      r.method  = m;
      r.version = v;
      return r;
   endfunction

endpackage

FILE: rtl/hrhp_req_if.sv
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       buffer_end;

   modport source (output valid, output byte_in, output buffer_end, input ready);
   modport sink (input valid, input byte_in, input buffer_end, output ready);
endinterface

FILE: rtl/hrhp_rsp_if.sv
interface hrhp_rsp_if import hrhp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       kind;
   logic [7:0]       byte_out;
   logic [POS_W-1:0] position;
   logic [1:0]       method;
   logic [7:0]       version;
   logic             last;

   modport source (output valid, output kind, output byte_out, output position,
                   output method, output version, output last, input ready);
   modport sink (input valid, input kind, input byte_out, input position,
                 input method, input version, input last, output ready);
endinterface

FILE: rtl/hrhp_core.sv
module hrhp_core import hrhp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] byte_in,
   input  logic       buffer_end,
   output push_type   push
);

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URI,
      PH_VERSION,
      PH_KEY,
      PH_SKIP,
      PH_VALUE,
      PH_DONE,
      PH_ERROR
   } phase_type;

   localparam logic [FC_W-1:0] GET_LEN       = FC_W'(3);
   localparam logic [FC_W-1:0] POST_LEN      = FC_W'(4);
   localparam logic [FC_W-1:0] VER_MAJOR_OFS = FC_W'(6);
   localparam logic [FC_W-1:0] VER_MINOR_OFS = FC_W'(8);
   localparam logic [FC_W-1:0] VER_CR_OFS    = FC_W'(9);
   localparam logic [FC_W-1:0] VER_LF_OFS    = FC_W'(10);
   localparam logic [FC_W-1:0] FIELD_MAX     = FC_W'(MAX_FIELD_LEN);

   phase_type       phase_ff, phase_in;
   logic [FC_W-1:0] fc_ff, fc_in;
   logic [7:0]      first_ff, first_in;
   method_type      method_ff, method_in;
   logic [7:0]      major_ff, major_in;
   logic            held_cr_ff, held_cr_in;

   logic [FC_W-1:0] fc_plus1;
   logic            fc_full;
   logic            live;
   logic [7:0]      lower_byte;
   logic [7:0]      version_calc;
   logic            emit;
   kind_type        emit_kind;
   logic [7:0]      emit_byte;
   logic [1:0]      n;
   rsp_item_type    item0, item1;
   rsp_item_type    err_item;

   assign fc_plus1     = FC_W'(fc_ff + 1'b1);
   assign fc_full      = fc_ff >= FIELD_MAX;
   assign live         = (phase_ff != PH_DONE) && (phase_ff != PH_ERROR);
   assign lower_byte   = (byte_in >= CH_UPPER_A && byte_in <= CH_UPPER_Z) ?
                         8'(byte_in + CASE_OFFSET) : byte_in;
   assign version_calc = 8'(8'(major_ff - CH_ZERO) * VERSION_RADIX) + 8'(byte_in - CH_ZERO);
   assign err_item     = ctrl_item(KIND_ERROR, METHOD_NONE, 8'd0);

   always_comb begin
      phase_in   = phase_ff;
      fc_in      = fc_ff;
      first_in   = first_ff;
      method_in  = method_ff;
      major_in   = major_ff;
      held_cr_in = held_cr_ff;
      n          = 2'd0;
      item0      = '0;
      item1      = '0;
      emit       = 1'b0;
      emit_kind  = KIND_URI;
      emit_byte  = byte_in;

      case (phase_ff)
         PH_METHOD: begin
            if (byte_in == CH_SP) begin
               if (fc_ff == GET_LEN && first_ff == CH_G) begin
                  method_in = METHOD_GET;
               end else if (fc_ff == POST_LEN && first_ff == CH_P) begin
                  method_in = METHOD_POST;
               end else begin
                  method_in = METHOD_NONE;
               end
               fc_in    = '0;
               phase_in = PH_URI;
            end else if (fc_full) begin
               item0    = err_item;
               n        = 2'd1;
               phase_in = PH_ERROR;
            end else begin
               if (fc_ff == '0) begin
                  first_in = byte_in;
               end
               fc_in = fc_plus1;
            end
         end
         PH_URI: begin
            if (byte_in == CH_SP) begin
               fc_in    = '0;
               phase_in = PH_VERSION;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_URI;
            end
         end
         PH_VERSION: begin
            fc_in = fc_plus1;
            if (fc_plus1 == VER_MAJOR_OFS) begin
               major_in = byte_in;
            end else if (fc_plus1 == VER_MINOR_OFS) begin
               major_in = version_calc;
            end else if (fc_plus1 == VER_CR_OFS) begin
               if (byte_in != CH_CR) begin
                  item0    = err_item;
                  n        = 2'd1;
                  phase_in = PH_ERROR;
               end
            end else if (fc_plus1 >= VER_LF_OFS) begin
               if (byte_in != CH_LF) begin
                  item0    = err_item;
                  n        = 2'd1;
                  phase_in = PH_ERROR;
               end else begin
                  item0    = ctrl_item(KIND_LINE, method_ff, major_ff);
                  n        = 2'd1;
                  fc_in    = '0;
                  phase_in = PH_KEY;
               end
            end
         end
         PH_KEY: begin
            if (fc_ff == '0 && (byte_in == CH_COLON || byte_in == CH_CR)) begin
               item0    = ctrl_item(KIND_HEAD, METHOD_NONE, 8'd0);
               n        = 2'd1;
               phase_in = PH_DONE;
            end else if (byte_in == CH_COLON) begin
               fc_in    = '0;
               phase_in = PH_SKIP;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_KEY;
               emit_byte = lower_byte;
            end
         end
         PH_SKIP: begin
            if (byte_in != CH_SP) begin
               phase_in   = PH_VALUE;
               held_cr_in = 1'b0;
               if (byte_in == CH_CR) begin
                  held_cr_in = 1'b1;
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_VALUE;
               end
            end
         end
         PH_VALUE: begin
            if (held_cr_ff) begin
               held_cr_in = 1'b0;
               if (byte_in == CH_LF) begin
                  item0    = ctrl_item(KIND_HEADER, METHOD_NONE, 8'd0);
                  n        = 2'd1;
                  fc_in    = '0;
                  phase_in = PH_KEY;
               end else if (fc_full) begin
                  item0    = err_item;
                  n        = 2'd1;
                  phase_in = PH_ERROR;
               end else begin
                  item0 = field_item(KIND_VALUE, CH_CR, POS_W'(fc_ff));
                  n     = 2'd1;
                  fc_in = fc_plus1;
                  if (byte_in == CH_CR) begin
                     held_cr_in = 1'b1;
                  end else if (fc_plus1 >= FIELD_MAX) begin
                     item1    = err_item;
                     n        = 2'd2;
                     phase_in = PH_ERROR;
                  end else begin
                     item1 = field_item(KIND_VALUE, byte_in, POS_W'(fc_plus1));
                     n     = 2'd2;
                     fc_in = FC_W'(fc_ff + 2'd2);
                  end
               end
            end else if (byte_in == CH_CR) begin
               held_cr_in = 1'b1;
            end else begin
               emit      = 1'b1;
               emit_kind = KIND_VALUE;
            end
         end
         default: begin
         end
      endcase

      if (emit) begin
         if (fc_full) begin
            item0    = err_item;
            n        = 2'd1;
            phase_in = PH_ERROR;
         end else begin
            item0 = field_item(emit_kind, emit_byte, POS_W'(fc_ff));
            n     = 2'd1;
            fc_in = fc_plus1;
         end
      end

      // truncated head: results of this byte are replaced by one error
      if (live && buffer_end && phase_in != PH_DONE) begin
         item0    = err_item;
         item1    = '0;
         n        = 2'd1;
         phase_in = PH_ERROR;
      end

      if (n == 2'd1) begin
         item0.last = 1'b1;
      end
      if (n == 2'd2) begin
         item1.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_METHOD;
         fc_ff      <= '0;
         first_ff   <= 8'd0;
         method_ff  <= METHOD_NONE;
         major_ff   <= 8'd0;
         held_cr_ff <= 1'b0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         fc_ff      <= fc_in;
         first_ff   <= first_in;
         method_ff  <= method_in;
         major_ff   <= major_in;
         held_cr_ff <= held_cr_in;
      end
   end

   assign push.count = fire ? n : 2'd0;
   assign push.item0 = item0;
   assign push.item1 = item1;

   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE || phase_ff == PH_ERROR) |=> $stable(phase_ff))
      else $error("parser left a terminal phase");

   a_two_from_cr: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (phase_ff == PH_VALUE && held_cr_ff))
      else $error("two results without a held CR");

   a_end_terminates: assert property (@(posedge clock) disable iff (reset)
      (fire && buffer_end) |=> (phase_ff == PH_DONE || phase_ff == PH_ERROR))
      else $error("buffer end did not terminate parsing");

endmodule

FILE: rtl/hrhp_rsp_fifo.sv
module hrhp_rsp_fifo import hrhp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  push_type     push,
   input  logic         pop,
   output rsp_item_type head,
   output logic         not_empty,
   output logic         has_room
);

   rsp_item_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_next1;

   assign wr_ptr_next1 = FIFO_PTR_W'(wr_ptr_ff + 1'b1);
   assign head         = mem_ff[rd_ptr_ff];
   assign not_empty    = count_ff != '0;
   assign has_room     = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_next1] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= FIFO_PTR_W'(wr_ptr_ff + push.count);
         rd_ptr_ff <= FIFO_PTR_W'(rd_ptr_ff + pop);
         count_ff  <= FIFO_CNT_W'(count_ff + push.count - pop);
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
      else $error("response queue overflow");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("response queue underflow");

endmodule

FILE: rtl/http_request_head_parser_unit.sv
// HTTP request head parser. Takes one request byte per cycle on req_ch while
// the response queue has room, and reports the head on rsp_ch as tagged
// responses: URI, key (lowercased) and value bytes with their field
// positions, request line done (method, version), header done, head done, or
// error. A byte is registered on acceptance and parsed, once the response
// queue has room, into a 4-entry response queue, from which responses are
// offered on rsp_ch. Sustained rate is one byte per cycle while each byte
// yields at most one response and the receiver takes every response; a lone
// CR inside a value yields two responses, and the output drains one response
// per cycle while the receiver is ready. After head done or error, further
// bytes are taken and yield nothing until reset.
module http_request_head_parser_unit import hrhp_pkg::*; (
   input logic         clock,
   input logic         reset,
   hrhp_req_if.sink    req_ch,
   hrhp_rsp_if.source  rsp_ch
);

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   logic         fire;
   logic         has_room;
   logic         not_empty;
   logic         pop;
   push_type     push;
   rsp_item_type head;

   assign fire         = in_valid_ff && has_room;
   assign req_ch.ready = !in_valid_ff || fire;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.byte_in;
         in_end_ff  <= req_ch.buffer_end;
      end
   end

   hrhp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .byte_in    (in_byte_ff),
      .buffer_end (in_end_ff),
      .push       (push)
   );

   hrhp_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .has_room  (has_room)
   );

   assign rsp_ch.valid    = not_empty;
   assign rsp_ch.kind     = head.kind;
   assign rsp_ch.byte_out = head.byte_out;
   assign rsp_ch.position = head.position;
   assign rsp_ch.method   = head.method;
   assign rsp_ch.version  = head.version;
   assign rsp_ch.last     = head.last;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import hrhp_pkg::*;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URI,
      PH_VERSION,
      PH_KEY,
      PH_SKIP,
      PH_VALUE,
      PH_DONE,
      PH_ERROR
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   hrhp_req_if req_ch ();
   hrhp_rsp_if rsp_ch ();

   http_request_head_parser_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // parser state as seen from the byte stream
   parse_phase_type ph;
   int unsigned     fcount;
   logic [7:0]      first_byte;
   method_type      method_code;
   logic [7:0]      major_digit;
   logic            held_cr;

   rsp_item_type byte_rsp[$];
   rsp_item_type rsp_expected[$];

   int unsigned src_idle_pct   = 0;
   int unsigned sink_stall_pct = 0;
   int unsigned hold_cycles    = 0;
   logic        rx_hold        = 1'b0;
   int unsigned mismatch_count = 0;
   int unsigned sent_count     = 0;

   function automatic void parser_reset();
      ph          = PH_METHOD;
      fcount      = 0;
      first_byte  = '0;
      method_code = METHOD_NONE;
      major_digit = '0;
      held_cr     = 1'b0;
   endfunction

   function automatic void put_rsp(input kind_type k, input logic [7:0] b,
                                   input int unsigned pos, input method_type m,
                                   input logic [7:0] v);
      rsp_item_type r;
      if (byte_rsp.size() >= 2) return;
      r          = '0;
      r.kind     = k;
      r.byte_out = b;
      r.position = pos[POS_W-1:0];
      r.method   = m;
      r.version  = v;
      r.last     = 1'b0;
      byte_rsp.push_back(r);
   endfunction

   function automatic void parse_error();
      put_rsp(KIND_ERROR, '0, 0, METHOD_NONE, '0);
      ph = PH_ERROR;
   endfunction

   function automatic logic field_byte(input kind_type k, input logic [7:0] b);
      if (fcount >= MAX_FIELD_LEN) begin
         parse_error();
         return 1'b0;
      end
      put_rsp(k, b, fcount, METHOD_NONE, '0);
      fcount++;
      return 1'b1;
   endfunction

   function automatic void value_byte(input logic [7:0] b);
      if (b == CH_CR) held_cr = 1'b1;
      else void'(field_byte(KIND_VALUE, b));
   endfunction

   function automatic void predict_rsp(input logic [7:0] b, input logic at_end);
      logic [7:0] lc;
      byte_rsp.delete();
      if (ph == PH_DONE || ph == PH_ERROR) return;
      case (ph)
         PH_METHOD: begin
            if (b == CH_SP) begin
               if (fcount == 3 && first_byte == CH_G) method_code = METHOD_GET;
               else if (fcount == 4 && first_byte == CH_P) method_code = METHOD_POST;
               else method_code = METHOD_NONE;
               fcount = 0;
               ph     = PH_URI;
            end else if (fcount >= MAX_FIELD_LEN) begin
               parse_error();
            end else begin
               if (fcount == 0) first_byte = b;
               fcount++;
            end
         end
         PH_URI: begin
            if (b == CH_SP) begin
               fcount = 0;
               ph     = PH_VERSION;
            end else begin
               void'(field_byte(KIND_URI, b));
            end
         end
         PH_VERSION: begin
            fcount++;
            if (fcount == 6) begin
               major_digit = b;
            end else if (fcount == 8) begin
               major_digit = (major_digit - CH_ZERO) * VERSION_RADIX + (b - CH_ZERO);
            end else if (fcount == 9) begin
               if (b != CH_CR) parse_error();
            end else if (fcount >= 10) begin
               if (b != CH_LF) begin
                  parse_error();
               end else begin
                  put_rsp(KIND_LINE, '0, 0, method_code, major_digit);
                  fcount = 0;
                  ph     = PH_KEY;
               end
            end
         end
         PH_KEY: begin
            if (fcount == 0 && (b == CH_COLON || b == CH_CR)) begin
               put_rsp(KIND_HEAD, '0, 0, METHOD_NONE, '0);
               ph = PH_DONE;
            end else if (b == CH_COLON) begin
               fcount = 0;
               ph     = PH_SKIP;
            end else begin
               lc = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
               void'(field_byte(KIND_KEY, lc));
            end
         end
         PH_SKIP: begin
            if (b != CH_SP) begin
               ph      = PH_VALUE;
               held_cr = 1'b0;
               value_byte(b);
            end
         end
         PH_VALUE: begin
            if (held_cr) begin
               held_cr = 1'b0;
               if (b == CH_LF) begin
                  put_rsp(KIND_HEADER, '0, 0, METHOD_NONE, '0);
                  fcount = 0;
                  ph     = PH_KEY;
               end else if (field_byte(KIND_VALUE, CH_CR)) begin
                  value_byte(b);
               end
            end else begin
               value_byte(b);
            end
         end
         default: ;
      endcase
      // truncated head: whatever this byte produced is replaced by one error
      if (at_end && ph != PH_DONE) begin
         byte_rsp.delete();
         parse_error();
      end
      if (byte_rsp.size() != 0) byte_rsp[byte_rsp.size() - 1].last = 1'b1;
      foreach (byte_rsp[i]) rsp_expected.push_back(byte_rsp[i]);
   endfunction

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) predict_rsp(req_ch.byte_in, req_ch.buffer_end);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rsp_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: kind=%0d byte=%h pos=%0d ",
                           rsp_ch.kind, rsp_ch.byte_out, rsp_ch.position,
                           "meth=%0d ver=%0d last=%0d",
                           rsp_ch.method, rsp_ch.version, rsp_ch.last);
            end else begin
               want = rsp_expected.pop_front();
               if (rsp_ch.kind !== want.kind || rsp_ch.byte_out !== want.byte_out ||
                   rsp_ch.position !== want.position || rsp_ch.method !== want.method ||
                   rsp_ch.version !== want.version || rsp_ch.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp kind=%0d byte=%h pos=%0d meth=%0d ver=%0d ",
                              want.kind, want.byte_out, want.position, want.method,
                              want.version,
                              "last=%0d | got kind=%0d byte=%h pos=%0d meth=%0d ",
                              want.last, rsp_ch.kind, rsp_ch.byte_out,
                              rsp_ch.position, rsp_ch.method,
                              "ver=%0d last=%0d", rsp_ch.version, rsp_ch.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rx_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // long receiver hold-off, counted here
   always begin
      wait (hold_cycles != 0);
      rx_hold <= 1'b1;
      repeat (hold_cycles) @(posedge clock);
      rx_hold <= 1'b0;
      hold_cycles = 0;
   end

   task automatic send_byte(input logic [7:0] b, input logic at_end = 1'b0);
      if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_ch.valid      <= 1'b1;
      req_ch.byte_in    <= b;
      req_ch.buffer_end <= at_end;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   function automatic logic [7:0] rand_key_byte(input bit first);
      logic [7:0] b;
      do begin
         case ($urandom_range(2))
            0:       b = 8'(CH_UPPER_A + $urandom_range(25));
            1:       b = 8'(CH_UPPER_A + CASE_OFFSET + $urandom_range(25));
            default: b = 8'($urandom_range(255));
         endcase
      end while (b == CH_COLON || (first && b == CH_CR));
      return b;
   endfunction

   // noisy headers carry CRs inside the key, CR-heavy values, or no colon at all
   task automatic send_header(input bit noisy);
      int unsigned klen;
      int unsigned vlen;
      logic [7:0]  b;
      logic        prev_cr;
      klen = noisy ? $urandom_range(1, 40) : $urandom_range(1, 12);
      for (int i = 0; i < klen; i++) begin
         b = rand_key_byte(i == 0);
         if (noisy && i != 0 && $urandom_range(3) == 0) b = CH_CR;
         send_byte(b);
      end
      if (!noisy || $urandom_range(2) != 0) send_byte(CH_COLON);
      repeat ($urandom_range(3)) send_byte(CH_SP);
      vlen    = $urandom_range(0, 24);
      prev_cr = 1'b0;
      for (int i = 0; i < vlen; i++) begin
         if (noisy ? ($urandom_range(1) == 0) : ($urandom_range(15) == 0)) b = CH_CR;
         else b = 8'($urandom_range(255));
         // keep the header open: no CR LF inside the value
         if (prev_cr && b == CH_LF) b = b ^ 8'h80;
         send_byte(b);
         prev_cr = (b == CH_CR);
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic test_request_line();
      string      tok;
      logic [7:0] major;
      logic [7:0] minor;
      logic [7:0] b;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      case ($urandom_range(6))
         0, 1:    tok = "GET";
         2:       tok = "POST";
         3:       tok = "GE";
         4:       tok = "PUT";
         5:       tok = "";
         default: tok = "PATCH";
      endcase
      major = ($urandom_range(3) != 0) ? 8'(CH_ZERO + $urandom_range(9)) :
                                         8'($urandom_range(255));
      minor = ($urandom_range(3) != 0) ? 8'(CH_ZERO + $urandom_range(9)) :
                                         8'($urandom_range(255));
      send_text(tok);
      send_byte(CH_SP);
      send_text("/");
      send_byte(8'h00);
      send_byte(8'hFF);
      repeat ($urandom_range(6)) begin
         do b = 8'($urandom_range(255)); while (b == CH_SP);
         send_byte(b);
      end
      send_byte(CH_SP);
      send_text("HTTP/");
      send_byte(major);
      send_text(".");
      send_byte(minor);
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic test_header_forms();
      // case-fold edges, CR inside a key, skipped spaces, lone CR in a value,
      // CR CR LF, and an empty value
      send_text("@AZ[");
      send_byte(CH_CR);
      send_text("`{:  v");
      send_byte(CH_CR);
      send_text("b");
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CH_CR);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_text("E:");
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic test_backpressure();
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_cycles    = 150;
      send_text("Fill: ");
      repeat (40) send_byte(8'($urandom_range(8'h21, 8'h7E)));
      send_byte(CH_CR);
      send_byte(CH_LF);
   endtask

   task automatic test_random_headers(input int unsigned n_bytes, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned stop_at;
      src_idle_pct   = idle_pct;
      sink_stall_pct = stall_pct;
      stop_at        = sent_count + n_bytes;
      while (sent_count < stop_at) send_header($urandom_range(9) == 0);
   endtask

   task automatic test_head_end();
      src_idle_pct   = 11;
      sink_stall_pct = 11;
      send_header(1'b0);
      case ($urandom_range(4))
         0: send_byte(CH_CR, 1'b1);
         1: send_byte(CH_COLON);
         2: begin
            send_text("Cut:ab");
            send_byte(CH_P, 1'b1);
         end
         3: begin
            send_text("Long:");
            repeat (MAX_FIELD_LEN + 1) send_byte(8'($urandom_range(8'h21, 8'h7E)));
         end
         default: begin
            for (int i = 0; i <= MAX_FIELD_LEN; i++) send_byte(rand_key_byte(i == 0));
         end
      endcase
      // parser has stopped; nothing more may come out
      repeat (4) send_byte(8'($urandom_range(255)));
      send_byte(CH_CR, 1'b1);
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.byte_in    = '0;
      req_ch.buffer_end = 1'b0;
      rsp_ch.ready      = 1'b0;
      parser_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_request_line();
      test_header_forms();
      test_backpressure();
      test_random_headers(110, 0, 0);
      test_random_headers(110, 59, 0);
      test_random_headers(110, 0, 59);
      test_random_headers(110, 11, 11);
      test_head_end();
      req_ch.valid <= 1'b0;

      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && rsp_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
